/* hdl/hbd_pkg.sv */
`default_nettype none
package hbd_pkg;

    localparam int NODE_COUNT  = 512;
    localparam int IDX_W       = 9;
    localparam int SYMBOL_BITS = 8;
    localparam int KIND_W      = 2;
    localparam int LEN_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int BIT_CNT_W   = $clog2(BYTE_W);
    localparam int ENTRY_W     = 2 * IDX_W + 1;

    localparam int IN_DATA_RAW_W  = IDX_W + 1 + IDX_W + IDX_W + LEN_W + BYTE_W;
    localparam int IN_DATA_W      = ((IN_DATA_RAW_W + 7) / 8) * 8;
    localparam int OUT_DATA_RAW_W = SYMBOL_BITS + 1 + LEN_W;
    localparam int OUT_DATA_W     = ((OUT_DATA_RAW_W + 7) / 8) * 8;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BYTE_W - 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CUR,
        ST_CHILD,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic                   message_done;
        logic                   tree_error;
        logic [LEN_W-1:0]       decoded_count;
    } t_result;

endpackage
`default_nettype wire

/* hdl/huffman_tree_bit_decoder_top.sv */
`default_nettype none
// A data byte is decoded bit by bit, each bit by a node table read of the current
// node, then of the chosen child; it ends after the last bit, on a tree error or on
// the message's final symbol, then flushes. Output stalls can hold it, and no new
// item is taken until it is done. Load, start and ignored items are taken when idle.
// Reset (i_rst_n low, synchronous) clears control state, counts and root index;
// the node table is not cleared.
module huffman_tree_bit_decoder_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // cfg data: root_index
    input  wire logic [hbd_pkg::IDX_W-1:0]      i_cfg_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: node_index, node_is_leaf, node_left, node_right, message_length,
    //        data_byte, zero pad
    input  wire logic [hbd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind
    input  wire logic [hbd_pkg::KIND_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata: symbol, message_done, decoded_count, zero pad
    output logic [hbd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: tree_error
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    import hbd_pkg::*;

    localparam int OFS_IDX   = 0;
    localparam int OFS_LEAF  = OFS_IDX + IDX_W;
    localparam int OFS_LEFT  = OFS_LEAF + 1;
    localparam int OFS_RIGHT = OFS_LEFT + IDX_W;
    localparam int OFS_LEN   = OFS_RIGHT + IDX_W;
    localparam int OFS_BYTE  = OFS_LEN + LEN_W;
    localparam logic [IDX_W:0] NODE_LIMIT = (IDX_W + 1)'(NODE_COUNT);

    logic [ENTRY_W-1:0] r_mem [NODE_COUNT];

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_root, n_root;
    logic [IDX_W-1:0]       r_cur, n_cur;
    logic [LEN_W-1:0]       r_left, n_left;
    logic [LEN_W-1:0]       r_done, n_done;
    logic [BYTE_W-1:0]      r_byte, n_byte;
    logic [BIT_CNT_W-1:0]   r_bit, n_bit;
    logic [ENTRY_W-1:0]     r_rdata;
    logic                   r_pend_valid, n_pend_valid;
    t_result                r_pend, n_pend;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_last, n_out_last;
    t_result                r_out, n_out;

    logic [IDX_W-1:0]       w_rd_addr;
    logic                   w_wr_en;
    logic [ENTRY_W-1:0]     w_wr_entry;
    logic [IDX_W-1:0]       w_in_idx;
    t_kind                  w_kind;
    logic                   w_in_acc;
    logic                   w_cfg_acc;
    logic                   w_out_free;
    logic                   w_can_push;
    logic                   w_leaf;
    logic [IDX_W-1:0]       w_ent_left;
    logic [IDX_W-1:0]       w_ent_right;
    logic [IDX_W-1:0]       w_child;
    logic                   w_cur_bad;
    logic                   w_child_bad;
    logic                   w_gen_err;
    logic                   w_gen_sym;
    logic                   w_push;
    logic                   w_bit_last;
    t_result                w_new;

    assign w_kind      = t_kind'(s_axis_tuser);
    assign w_in_idx    = s_axis_tdata[OFS_IDX +: IDX_W];
    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_can_push  = !r_pend_valid || w_out_free;
    assign w_leaf      = r_rdata[ENTRY_W-1];
    assign w_ent_left  = r_rdata[IDX_W +: IDX_W];
    assign w_ent_right = r_rdata[0 +: IDX_W];
    assign w_child     = r_byte[BYTE_W-1] ? w_ent_right : w_ent_left;
    assign w_cur_bad   = w_leaf || ({1'b0, r_cur} >= NODE_LIMIT);
    assign w_child_bad = ({1'b0, w_child} >= NODE_LIMIT) || (w_child == r_cur);
    assign w_gen_err   = (r_state == ST_CUR) && (w_cur_bad || w_child_bad);
    assign w_gen_sym   = (r_state == ST_CHILD) && w_leaf;
    assign w_push      = (w_gen_err || w_gen_sym) && w_can_push;
    assign w_bit_last  = (r_bit == LAST_BIT);

    assign w_wr_en    = w_in_acc && (w_kind == KIND_LOAD) &&
                        ({1'b0, w_in_idx} < NODE_LIMIT);
    assign w_wr_entry = {s_axis_tdata[OFS_LEAF],
                         s_axis_tdata[OFS_LEFT +: IDX_W],
                         s_axis_tdata[OFS_RIGHT +: IDX_W]};

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out.tree_error;
    assign m_axis_tdata  = OUT_DATA_W'({r_out.decoded_count, r_out.message_done,
                                        r_out.symbol});

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_in_idx] <= w_wr_entry;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (w_kind == KIND_DATA) && (r_left != '0)) begin
                    n_state = ST_CUR;
                end
            end
            ST_CUR: begin
                if (w_gen_err) begin
                    if (w_can_push) begin
                        n_state = ST_FLUSH;
                    end
                end else begin
                    n_state = ST_CHILD;
                end
            end
            ST_CHILD: begin
                if (w_leaf) begin
                    if (w_can_push) begin
                        n_state = ((r_left == LEN_W'(1)) || w_bit_last) ? ST_FLUSH : ST_CUR;
                    end
                end else begin
                    n_state = w_bit_last ? ST_FLUSH : ST_CUR;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_root       = r_root;
        n_cur        = r_cur;
        n_left       = r_left;
        n_done       = r_done;
        n_byte       = r_byte;
        n_bit        = r_bit;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_last   = r_out_last;
        n_out        = r_out;
        w_rd_addr    = r_cur;
        w_new        = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_cfg_acc) begin
                    n_root    = i_cfg_data;
                    n_cur     = i_cfg_data;
                    w_rd_addr = i_cfg_data;
                end
                if (w_in_acc) begin
                    case (w_kind)
                        KIND_START: begin
                            n_left = s_axis_tdata[OFS_LEN +: LEN_W];
                            n_done = '0;
                            n_cur  = n_root;
                        end
                        KIND_DATA: begin
                            n_byte = s_axis_tdata[OFS_BYTE +: BYTE_W];
                            n_bit  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CUR: begin
                if (w_gen_err) begin
                    w_new.decoded_count = r_done;
                    w_new.tree_error    = 1'b1;
                    if (w_can_push) begin
                        n_cur = r_root;
                    end
                end else begin
                    n_cur     = w_child;
                    w_rd_addr = w_child;
                end
            end
            ST_CHILD: begin
                w_new.symbol        = w_ent_left[SYMBOL_BITS-1:0];
                w_new.message_done  = (r_left == LEN_W'(1));
                w_new.decoded_count = r_done + LEN_W'(1);
                if (w_leaf) begin
                    if (w_can_push) begin
                        n_left    = r_left - LEN_W'(1);
                        n_done    = r_done + LEN_W'(1);
                        n_cur     = r_root;
                        w_rd_addr = r_root;
                        n_byte    = {r_byte[BYTE_W-2:0], 1'b0};
                        n_bit     = r_bit + BIT_CNT_W'(1);
                    end
                end else begin
                    n_byte = {r_byte[BYTE_W-2:0], 1'b0};
                    n_bit  = r_bit + BIT_CNT_W'(1);
                end
            end
            ST_FLUSH: begin
                if (r_pend_valid && w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    n_out        = r_pend;
                    n_pend_valid = 1'b0;
                end
            end
            default: ;
        endcase

        if (w_push) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out_last  = 1'b0;
                n_out       = r_pend;
            end
            n_pend_valid = 1'b1;
            n_pend       = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_root       <= '0;
            r_cur        <= '0;
            r_left       <= '0;
            r_done       <= '0;
            r_bit        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_root       <= n_root;
            r_cur        <= n_cur;
            r_left       <= n_left;
            r_done       <= n_done;
            r_bit        <= n_bit;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

endmodule
`default_nettype wire
